>>> hw/rtl/sqp_pkg.sv
// ----------------------------------------------------------------------------
// sqp_pkg
// Shared types and fixed-point constants for the quadrant sine pipeline.
// ----------------------------------------------------------------------------
package sqp_pkg;

  localparam int unsigned FracBits = 30;

  // 2/pi as unsigned Q0.32, truncated
  localparam logic [31:0] TwoOverPiQ32 = 32'd2734261102;
  // pi/2 as Q2.30, rounded (fits in 31 unsigned bits)
  localparam logic [30:0] HalfPiQ30 = 31'd1686629713;

  // odd polynomial coefficients, Q2.30
  localparam logic signed [31:0] CoefP1 = 32'sd1073738184;
  localparam logic signed [31:0] CoefP3 = -32'sd178937260;
  localparam logic signed [31:0] CoefP5 = 32'sd8918886;
  localparam logic signed [31:0] CoefP7 = -32'sd197193;

  localparam logic signed [31:0] OneQ30 = 32'sd1073741824;

  typedef logic signed [31:0] angle_t;
  typedef logic signed [31:0] sine_t;

  // reduced argument, Q2.30
  typedef logic signed [31:0] rarg_t;

  typedef struct packed {
    rarg_t r;
    logic  last;
  } red_t;

  typedef struct packed {
    logic signed [32:0] b;
    logic signed [29:0] m;
    logic               last;
  } poly_t;

endpackage

>>> hw/rtl/sqp_if.sv
// ----------------------------------------------------------------------------
// sqp_in_if / sqp_out_if
// Valid/ready stream channels carrying angles in and sine values out.
// ----------------------------------------------------------------------------
interface sqp_in_if;
  logic            valid;
  logic            ready;
  sqp_pkg::angle_t angle;
  logic            last_in;

  modport source (output valid, output angle, output last_in, input ready);
  modport sink   (input valid, input angle, input last_in, output ready);
endinterface

interface sqp_out_if;
  logic           valid;
  logic           ready;
  sqp_pkg::sine_t sine;
  logic           last_out;

  modport source (output valid, output sine, output last_out, input ready);
  modport sink   (input valid, input sine, input last_out, output ready);
endinterface

>>> hw/rtl/sine_quadrant_polynomial.sv
// ----------------------------------------------------------------------------
// sine_quadrant_polynomial
// Streaming sine of a Q8.24 angle, result in Q2.30, one transaction per clock while out_o is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : valid/ready channel with angle (Q8.24 radians) and last_in.
//   out_o : valid/ready channel with sine (Q2.30, clamped to +-1.0) and
//           last_out, the echo of last_in.
//   Each input transaction yields exactly one output transaction, in order.
//   The path from acceptance to out_o.valid runs through 4 range-reduction
//   stages, 4 polynomial stages and the output register. Throughput is one
//   transaction per cycle while out_o.ready holds; the multipliers sit inside the stages.
//   Every stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles are squeezed out while the receiver
//   stalls and in_i.ready falls only when all 9 stages hold data.
//   Asynchronous reset empties the pipeline; results in flight are dropped.
//   There is no configuration and no state between transactions.
// ----------------------------------------------------------------------------
module sine_quadrant_polynomial (
  input  logic       clk_i,
  input  logic       rst_ni,
  sqp_in_if.sink     in_i,
  sqp_out_if.source  out_o
);
  import sqp_pkg::*;

  logic  red_valid, red_ready;
  red_t  red;
  logic  poly_valid, poly_ready;
  poly_t poly;

  sqp_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .angle_i     (in_i.angle),
    .last_i      (in_i.last_in),
    .out_valid_o (red_valid),
    .out_ready_i (red_ready),
    .out_o       (red)
  );

  sqp_poly u_poly (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_ready_o  (red_ready),
    .in_i        (red),
    .out_valid_o (poly_valid),
    .out_ready_i (poly_ready),
    .out_o       (poly)
  );

  sqp_sat u_sat (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (poly_valid),
    .in_ready_o  (poly_ready),
    .in_i        (poly),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sine_o      (out_o.sine),
    .last_o      (out_o.last_out)
  );

  // reduced argument stays within a quarter turn plus rounding slack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_valid |-> ((red.r <= 32'sd1686633809) && (red.r >= -32'sd1686633809)))
    else $error("reduced argument out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.sine <= OneQ30) && (out_o.sine >= -OneQ30)))
    else $error("sine outside clamp range");

  // a free receiver must never block the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.ready |-> in_i.ready)
    else $error("input stalled while output is ready");

endmodule

>>> hw/rtl/sqp_reduce.sv
// ----------------------------------------------------------------------------
// sqp_reduce
// Four-stage range reduction: magnitude, quadrant, quadrant offset, reduced
// and sign-corrected argument.
// ----------------------------------------------------------------------------
module sqp_reduce (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sqp_pkg::angle_t angle_i,
  input  logic            last_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sqp_pkg::red_t   out_o
);
  import sqp_pkg::*;

  logic [3:0] v_q;
  logic [3:0] en;

  // stage 1: magnitude
  logic [31:0] raw;
  logic [31:0] mag_d, mag1_q;
  logic        neg1_q, last1_q;

  // stage 2: quadrant
  logic [63:0] prod;
  logic [6:0]  q_d, q2_q;
  logic [31:0] mag2_q;
  logic        neg2_q, last2_q;

  // stage 3: quadrant offset, odd quadrants take one more pi/2
  logic [7:0]  qeff;
  logic [38:0] qh_d, qh3_q;
  logic [31:0] mag3_q;
  logic        flip_d, flip3_q, last3_q;

  // stage 4: reduced argument
  logic signed [39:0] diff, rsel;
  rarg_t              r_d, r4_q;
  logic               last4_q;

  // advance a stage when it is empty or the next one advances
  always_comb begin
    en[3] = !v_q[3] || out_ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  assign raw   = $unsigned(angle_i);
  assign mag_d = raw[31] ? (32'd0 - raw) : raw;

  assign prod = 64'(mag1_q) * 64'(TwoOverPiQ32);
  assign q_d  = prod[62:56];

  assign qeff   = 8'(q2_q) + 8'(q2_q[0]);
  assign qh_d   = 39'(qeff) * 39'(HalfPiQ30);
  assign flip_d = q2_q[0] ^ q2_q[1] ^ neg2_q;

  assign diff = $signed({2'b00, mag3_q, 6'b000000}) - $signed({1'b0, qh3_q});
  assign rsel = flip3_q ? (40'sd0 - diff) : diff;
  assign r_d  = rsel[31:0];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mag1_q  <= mag_d;
      neg1_q  <= raw[31];
      last1_q <= last_i;
    end
    if (en[1]) begin
      q2_q    <= q_d;
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      last2_q <= last1_q;
    end
    if (en[2]) begin
      qh3_q   <= qh_d;
      mag3_q  <= mag2_q;
      flip3_q <= flip_d;
      last3_q <= last2_q;
    end
    if (en[3]) begin
      r4_q    <= r_d;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o.r     = r4_q;
  assign out_o.last  = last4_q;

endmodule

>>> hw/rtl/sqp_poly.sv
// ----------------------------------------------------------------------------
// sqp_poly
// Four-stage Estrin evaluation of the odd degree-7 polynomial; hands on the
// low half b and the high product m = a * r^4.
// ----------------------------------------------------------------------------
module sqp_poly (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sqp_pkg::red_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sqp_pkg::poly_t out_o
);
  import sqp_pkg::*;

  logic [3:0] v_q;
  logic [3:0] en;

  // stage 1: r^2 and the coefficient products
  logic signed [63:0] r2_f, p7r_f, p5r_f, p3r_f, p1r_f;
  logic signed [32:0] r2_q;
  logic signed [19:0] p7r_q;
  logic signed [25:0] p5r_q;
  logic signed [29:0] p3r_q;
  logic signed [31:0] p1r_q;
  logic               last1_q;

  // stage 2: odd terms times r^2, and r^4
  logic signed [63:0] t7_f, t3_f;
  logic [63:0]        r4_f;
  logic signed [21:0] t7_q;
  logic signed [31:0] t3_q;
  logic [33:0]        r4_q;
  logic signed [25:0] p5r2_q;
  logic signed [31:0] p1r2_q;
  logic               last2_q;

  // stage 3: pair sums
  logic signed [26:0] a_q;
  logic signed [32:0] b3_q;
  logic [33:0]        r4b_q;
  logic               last3_q;

  // stage 4: high half times r^4
  logic signed [63:0] m_f;
  logic signed [29:0] m4_q;
  logic signed [32:0] b4_q;
  logic               last4_q;

  always_comb begin
    en[3] = !v_q[3] || out_ready_i;
    en[2] = !v_q[2] || en[3];
    en[1] = !v_q[1] || en[2];
    en[0] = !v_q[0] || en[1];
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2];
    end
  end

  // products floor toward minus infinity: arithmetic shift of the full product
  assign r2_f  = 64'(in_i.r) * 64'(in_i.r);
  assign p7r_f = 64'(CoefP7) * 64'(in_i.r);
  assign p5r_f = 64'(CoefP5) * 64'(in_i.r);
  assign p3r_f = 64'(CoefP3) * 64'(in_i.r);
  assign p1r_f = 64'(CoefP1) * 64'(in_i.r);

  assign t7_f = 64'(p7r_q) * 64'(r2_q);
  assign t3_f = 64'(p3r_q) * 64'(r2_q);
  // r^2 is never negative and stays below 2^32
  assign r4_f = 64'(r2_q[31:0]) * 64'(r2_q[31:0]);

  assign m_f = 64'(a_q) * 64'($signed({1'b0, r4b_q}));

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r2_q    <= 33'(r2_f >>> FracBits);
      p7r_q   <= 20'(p7r_f >>> FracBits);
      p5r_q   <= 26'(p5r_f >>> FracBits);
      p3r_q   <= 30'(p3r_f >>> FracBits);
      p1r_q   <= 32'(p1r_f >>> FracBits);
      last1_q <= in_i.last;
    end
    if (en[1]) begin
      t7_q    <= 22'(t7_f >>> FracBits);
      t3_q    <= 32'(t3_f >>> FracBits);
      r4_q    <= r4_f[63:30];
      p5r2_q  <= p5r_q;
      p1r2_q  <= p1r_q;
      last2_q <= last1_q;
    end
    if (en[2]) begin
      a_q     <= 27'(t7_q) + 27'(p5r2_q);
      b3_q    <= 33'(t3_q) + 33'(p1r2_q);
      r4b_q   <= r4_q;
      last3_q <= last2_q;
    end
    if (en[3]) begin
      m4_q    <= 30'(m_f >>> FracBits);
      b4_q    <= b3_q;
      last4_q <= last3_q;
    end
  end

  assign out_valid_o = v_q[3];
  assign out_o.b     = b4_q;
  assign out_o.m     = m4_q;
  assign out_o.last  = last4_q;

endmodule

>>> hw/rtl/sqp_sat.sv
// ----------------------------------------------------------------------------
// sqp_sat
// Final sum and clamp to +-1.0 in Q2.30, held in the output register.
// ----------------------------------------------------------------------------
module sqp_sat (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sqp_pkg::poly_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sqp_pkg::sine_t sine_o,
  output logic           last_o
);
  import sqp_pkg::*;

  logic               v_q;
  logic               en;
  logic signed [33:0] sum;
  sine_t              sine_d, sine_q;
  logic               last_q;

  assign en         = !v_q || out_ready_i;
  assign in_ready_o = en;

  assign sum = 34'(in_i.b) + 34'(in_i.m);

  always_comb begin
    if (sum > 34'(OneQ30)) begin
      sine_d = OneQ30;
    end else if (sum < -34'(OneQ30)) begin
      sine_d = -OneQ30;
    end else begin
      sine_d = sum[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sine_q <= sine_d;
      last_q <= in_i.last;
    end
  end

  assign out_valid_o = v_q;
  assign sine_o      = sine_q;
  assign last_o      = last_q;

endmodule
